// ===== hw/rtl/depth_to_point_box_hit_test_unit_macros.svh =====
// assertion helpers for the depth to point unit
`ifndef DEPTH_TO_POINT_BOX_HIT_TEST_UNIT_MACROS_SVH
`define DEPTH_TO_POINT_BOX_HIT_TEST_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define DTP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define DTP_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("%m failed");
`else
`define DTP_ASSERT(label, clk, rst_n, prop)
`define DTP_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/dtp_pkg.sv =====
package dtp_pkg;
  localparam int unsigned MaxBoxes     = 8;
  localparam int unsigned SampleStride = 10;
  localparam int unsigned FracBits     = 16;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 16;

  localparam logic [CfgIdxW-1:0] RegFocal  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPixel  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWidth  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHeight = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBoxes  = 3'd4;

  localparam logic CmdPixel = 1'b0;
  localparam logic CmdBox   = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [15:0]        depth;
    logic [2:0]         box_index;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [7:0]         hit_mask;
    logic               frame_end;
  } out_item_t;
endpackage

// ===== hw/rtl/dtp_ram.sv =====
// generic single-port ram, registered read
module dtp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== hw/rtl/depth_to_point_box_hit_test_unit.sv =====
// Depth pixels in raster order become Q15.16 points (x, y, z) with one result
// item per pixel; a box load (cmd 1) writes six bounds, one per cycle, into a
// single-port bound ram and clears the box's hit flag, giving no result. Per
// pixel, x and y each go through one shared restoring divider, one quotient bit
// per cycle (two passes of 42 bits, each after a multiply setup), and z is
// formed by a 16 by 32 bit multiply by the reciprocal of ten. Every
// SAMPLE_STRIDE-th pixel then reads the active boxes' bounds from the ram one at
// a time, each bound read, awaited and compared before the next; a box stops at
// its first failing bound. There is no clearing pass; the hit test must not be
// enabled for a box that was never loaded. The block holds one item at a time
// and is ready again once its result has left the output or a box load ends.
`include "depth_to_point_box_hit_test_unit_macros.svh"
module depth_to_point_box_hit_test_unit #(
  parameter int unsigned MaxBoxes     = dtp_pkg::MaxBoxes,
  parameter int unsigned SampleStride = dtp_pkg::SampleStride,
  parameter int unsigned FracBits     = dtp_pkg::FracBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dtp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dtp_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  dtp_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output dtp_pkg::out_item_t             out_item_o
);
  localparam int unsigned ScaleUp   = (FracBits >= 16) ? FracBits - 16 : 0;
  localparam int unsigned ScaleDown = (FracBits < 16) ? 16 - FracBits : 0;
  // numerator: 10 bits diff * 16 depth * 16 pitch, shifted up
  localparam int unsigned NumW    = 42 + ScaleUp;
  localparam int unsigned DenW    = 20 + ScaleDown;
  localparam int unsigned QW      = NumW;
  localparam int unsigned QCntW   = $clog2(QW + 1);
  localparam int unsigned BDepth  = MaxBoxes * 6;
  localparam int unsigned BAddrW  = $clog2(BDepth);
  localparam int unsigned BoxW    = $clog2(MaxBoxes);
  localparam int unsigned BoxCntW = $clog2(MaxBoxes + 1);
  localparam int unsigned PhW     = $clog2(SampleStride + 1);
  // reciprocal of ten scaled by 2^(FracBits+19), rounded up, exact floor for 16 bit depth
  localparam int unsigned RecipSh = 19;
  localparam int unsigned RecipW  = FracBits + 16;
  localparam int unsigned ZqW     = FracBits + 13;
  localparam logic [RecipW-1:0] Recip10 =
    RecipW'((64'd1 << (FracBits + RecipSh)) / 64'd10 + 64'd1);

  typedef enum logic [3:0] {
    StIdle, StLoad, StMulA, StMulB, StDiv, StDivDone, StTestRd, StTestWait,
    StTestCmp, StOut
  } state_e;

  state_e state_q;
  dtp_pkg::in_item_t item_q;
  dtp_pkg::out_item_t res_q;
  logic [15:0] focal_q, pixel_q;
  logic [10:0] width_q, height_q;
  logic [3:0]  boxes_q;
  logic [9:0]  col_q, row_q;
  logic [PhW-1:0] phase_q;
  logic [MaxBoxes-1:0] hit_q, box_hit_q;
  logic [2:0]  bcnt_q;
  logic [BoxCntW-1:0] box_q;
  logic axis_q;
  logic neg_q;
  logic [25:0] prod_q;
  logic [NumW-1:0] num_q;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   rem_q;
  logic [QW-1:0]   quo_q;
  logic [QCntW-1:0] qcnt_q;
  logic signed [31:0] px_q, py_q;

  // ram access
  logic ram_we;
  logic [BAddrW-1:0] ram_addr;
  logic [31:0] ram_wdata, ram_rdata;

  dtp_ram #(.Width(32), .Depth(BDepth)) u_bounds (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  logic [BAddrW+2:0] base_addr;
  assign base_addr = (state_q == StLoad)
                     ? (BAddrW + 3)'(item_q.box_index) * (BAddrW + 3)'(6)
                     : (BAddrW + 3)'(box_q) * (BAddrW + 3)'(6);
  assign ram_addr = BAddrW'(base_addr + (BAddrW + 3)'(bcnt_q));
  assign ram_we   = (state_q == StLoad);
  always_comb begin
    unique case (bcnt_q)
      3'd0:    ram_wdata = item_q.box_min_x;
      3'd1:    ram_wdata = item_q.box_max_x;
      3'd2:    ram_wdata = item_q.box_min_y;
      3'd3:    ram_wdata = item_q.box_max_y;
      3'd4:    ram_wdata = item_q.box_min_z;
      default: ram_wdata = item_q.box_max_z;
    endcase
  end

  // position offset from the optical center
  logic [10:0] center, pos, diff_raw;
  logic [9:0]  diff;
  logic        pos_neg;
  assign center   = axis_q ? 11'd240 : 11'd320;
  assign pos      = axis_q ? {1'b0, row_q} : {1'b0, col_q};
  assign pos_neg  = pos > center;
  assign diff_raw = pos_neg ? pos - center : center - pos;
  assign diff     = diff_raw[9:0];

  // z by reciprocal multiply, one multiplier
  logic [RecipW+15:0] zprod;
  logic [ZqW-1:0] zq;
  logic signed [31:0] pz;
  assign zprod = (RecipW + 16)'(item_q.depth) * (RecipW + 16)'(Recip10);
  assign zq    = zprod[RecipSh +: ZqW];
  assign pz    = (64'(zq) > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(zq);

  // one restoring division step
  logic [DenW:0] rem_sh;
  logic [DenW:0] rem_sub;
  assign rem_sh  = {rem_q[DenW-1:0], num_q[NumW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  // saturate and sign the quotient
  logic signed [31:0] lat;
  always_comb begin
    if (neg_q) begin
      lat = (quo_q >= QW'(64'h8000_0000)) ? 32'sh8000_0000 : -$signed(32'(quo_q));
    end else begin
      lat = (quo_q > QW'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : 32'(quo_q);
    end
  end

  // bound compare for the current box
  logic signed [31:0] pv, bnd;
  logic in_b;
  assign bnd = ram_rdata;
  always_comb begin
    unique case (bcnt_q[2:1])
      2'd0:    pv = px_q;
      2'd1:    pv = py_q;
      default: pv = res_q.point_z;
    endcase
  end
  assign in_b = bcnt_q[0] ? (pv < bnd) : (pv > bnd);

  logic [BoxCntW-1:0] nbox;
  assign nbox = (32'(boxes_q) > MaxBoxes) ? BoxCntW'(MaxBoxes) : BoxCntW'(boxes_q);

  logic [10:0] wlim, hlim;
  assign wlim = (width_q == 11'd0) ? 11'd1 : (width_q > 11'd1024 ? 11'd1024 : width_q);
  assign hlim = (height_q == 11'd0) ? 11'd1 : (height_q > 11'd1024 ? 11'd1024 : height_q);

  // raster position and stride phase after this pixel
  logic col_wrap, row_wrap;
  logic [PhW-1:0] phase_inc;
  assign col_wrap  = (11'(col_q) + 11'd1) >= wlim;
  assign row_wrap  = (11'(row_q) + 11'd1) >= hlim;
  assign phase_inc = (32'(phase_q) + 1 >= SampleStride) ? '0 : phase_q + 1'b1;

  logic [15:0] focal_eff;
  assign focal_eff = (focal_q == 16'd0) ? 16'd1 : focal_q;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_item_o  = res_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      focal_q  <= 16'd120;
      pixel_q  <= 16'd13658;
      width_q  <= 11'd640;
      height_q <= 11'd480;
      boxes_q  <= 4'd0;
      col_q    <= '0;
      row_q    <= '0;
      phase_q  <= '0;
      hit_q    <= '0;
      bcnt_q   <= '0;
      box_q    <= '0;
      axis_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          dtp_pkg::RegFocal:  focal_q  <= cfg_data_i;
          dtp_pkg::RegPixel:  pixel_q  <= cfg_data_i;
          dtp_pkg::RegWidth:  width_q  <= cfg_data_i[10:0];
          dtp_pkg::RegHeight: height_q <= cfg_data_i[10:0];
          dtp_pkg::RegBoxes:  boxes_q  <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            item_q <= in_item_i;
            bcnt_q <= '0;
            axis_q <= 1'b0;
            if (in_item_i.cmd == dtp_pkg::CmdBox) begin
              if (32'(in_item_i.box_index) < MaxBoxes) begin
                state_q <= StLoad;
              end
            end else begin
              state_q <= StMulA;
            end
          end
        end
        StLoad: begin
          if (bcnt_q == 3'd5) begin
            bcnt_q  <= '0;
            hit_q[BoxW'(item_q.box_index)] <= 1'b0;
            state_q <= StIdle;
          end else begin
            bcnt_q <= bcnt_q + 3'd1;
          end
        end
        StMulA: begin
          neg_q   <= pos_neg;
          prod_q  <= 26'(diff) * 26'(item_q.depth);
          res_q.point_z <= pz;
          state_q <= StMulB;
        end
        StMulB: begin
          num_q  <= NumW'(42'(prod_q) * 42'(pixel_q)) << ScaleUp;
          den_q  <= DenW'((20'(focal_eff) * 20'd10)) << ScaleDown;
          rem_q  <= '0;
          quo_q  <= '0;
          qcnt_q <= '0;
          state_q <= StDiv;
        end
        StDiv: begin
          num_q <= num_q << 1;
          if (!rem_sub[DenW]) begin
            rem_q <= rem_sub;
            quo_q <= {quo_q[QW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[QW-2:0], 1'b0};
          end
          if (qcnt_q == QCntW'(QW - 1)) begin
            state_q <= StDivDone;
          end
          qcnt_q <= qcnt_q + 1'b1;
        end
        StDivDone: begin
          if (!axis_q) begin
            px_q    <= lat;
            axis_q  <= 1'b1;
            state_q <= StMulA;
          end else begin
            py_q      <= lat;
            box_q     <= '0;
            bcnt_q    <= '0;
            box_hit_q <= '0;
            if (phase_q == '0 && nbox != '0) begin
              state_q <= StTestRd;
            end else begin
              state_q <= StTestCmp;
            end
          end
        end
        StTestRd: begin
          state_q <= StTestWait;
        end
        StTestWait: begin
          // bound for the current axis arrives now
          if (!in_b) begin
            box_hit_q[BoxW'(box_q)] <= 1'b0;
          end else if (bcnt_q == 3'd0) begin
            box_hit_q[BoxW'(box_q)] <= 1'b1;
          end
          if (bcnt_q == 3'd5 || !in_b) begin
            bcnt_q <= '0;
            box_q  <= box_q + 1'b1;
          end else begin
            bcnt_q <= bcnt_q + 3'd1;
          end
          state_q <= StTestCmp;
        end
        StTestCmp: begin
          if (box_q >= nbox || phase_q != '0) begin
            hit_q <= hit_q | box_hit_q;
            res_q.point_x   <= px_q;
            res_q.point_y   <= py_q;
            res_q.hit_mask  <= 8'(hit_q | box_hit_q);
            res_q.frame_end <= col_wrap && row_wrap;
            phase_q <= (col_wrap && row_wrap) ? '0 : phase_inc;
            if (col_wrap) begin
              col_q <= '0;
              if (row_wrap) begin
                row_q <= '0;
              end else begin
                row_q <= row_q + 10'd1;
              end
            end else begin
              col_q <= col_q + 10'd1;
            end
            state_q <= StOut;
          end else begin
            state_q <= StTestRd;
          end
        end
        StOut: begin
          if (out_ready_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `DTP_ASSERT(a_ready_idle, clk_i, rst_ni, in_ready_o |-> !out_valid_o)
  `DTP_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> out_valid_o)
  `DTP_ASSERT_NEVER(a_end_counters, clk_i, rst_ni, out_valid_o && res_q.frame_end && (col_q != '0 || row_q != '0))
endmodule

// ===== bench/depth_to_point_box_hit_test_unit_tb.sv =====
`timescale 1ns / 1ps

module depth_to_point_box_hit_test_unit_tb;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned SettleCycles = 300;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [dtp_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [dtp_pkg::CfgDataW-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  dtp_pkg::in_item_t in_item_i;
  logic out_valid_o;
  logic out_ready_i;
  dtp_pkg::out_item_t out_item_o;

  depth_to_point_box_hit_test_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_item_i(in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o(out_item_o)
  );

  // predictor copy of registers and state
  logic [15:0] m_focal;
  logic [15:0] m_pixel;
  logic [10:0] m_width;
  logic [10:0] m_height;
  logic [3:0] m_boxes;
  int unsigned m_col;
  int unsigned m_row;
  int unsigned m_phase;
  logic signed [31:0] m_bounds[dtp_pkg::MaxBoxes*6];
  logic [7:0] m_hits;

  dtp_pkg::out_item_t expected_points[$];
  int unsigned errors;
  int unsigned cycles;
  bit no_idle;

  // clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    out_ready_i <= no_idle ? 1'b1 : ($urandom_range(99) >= 32);
  end

  // saturating lateral coordinate
  function automatic logic signed [31:0] lateral_coord(int unsigned pos, int unsigned center,
                                                       logic [15:0] d);
    longint unsigned diff;
    longint unsigned f;
    longint unsigned mag;
    bit neg;
    neg = pos > center;
    diff = neg ? pos - center : center - pos;
    f = (m_focal == 0) ? 1 : m_focal;
    mag = (diff * d * m_pixel) / (10 * f);
    if (neg) return (mag >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(mag[31:0]);
    return (mag > 64'h7fff_ffff) ? 32'sh7fff_ffff : $signed(mag[31:0]);
  endfunction

  function automatic logic signed [31:0] depth_coord(logic [15:0] d);
    longint unsigned zmag;
    zmag = ({48'd0, d} << dtp_pkg::FracBits) / 10;
    return zmag[31:0];
  endfunction

  function automatic int unsigned clamp_size(logic [10:0] s);
    if (s == 0) return 1;
    if (s > 1024) return 1024;
    return s;
  endfunction

  // advance the predictor by one accepted item
  task automatic predict_item(dtp_pkg::in_item_t it);
    dtp_pkg::out_item_t r;
    int unsigned nb;
    if (it.cmd == dtp_pkg::CmdBox) begin
      m_bounds[it.box_index*6+0] = it.box_min_x;
      m_bounds[it.box_index*6+1] = it.box_max_x;
      m_bounds[it.box_index*6+2] = it.box_min_y;
      m_bounds[it.box_index*6+3] = it.box_max_y;
      m_bounds[it.box_index*6+4] = it.box_min_z;
      m_bounds[it.box_index*6+5] = it.box_max_z;
      m_hits[it.box_index] = 1'b0;
      return;
    end
    r.point_x = lateral_coord(m_col, 320, it.depth);
    r.point_y = lateral_coord(m_row, 240, it.depth);
    r.point_z = depth_coord(it.depth);
    if (m_phase == 0) begin
      nb = (m_boxes < dtp_pkg::MaxBoxes) ? m_boxes : dtp_pkg::MaxBoxes;
      for (int b = 0; b < nb; b++) begin
        if (r.point_x > m_bounds[b*6+0] && r.point_x < m_bounds[b*6+1] &&
            r.point_y > m_bounds[b*6+2] && r.point_y < m_bounds[b*6+3] &&
            r.point_z > m_bounds[b*6+4] && r.point_z < m_bounds[b*6+5])
          m_hits[b] = 1'b1;
      end
    end
    r.frame_end = 1'b0;
    m_phase = (m_phase + 1 >= dtp_pkg::SampleStride) ? 0 : m_phase + 1;
    if (m_col + 1 >= clamp_size(m_width)) begin
      m_col = 0;
      if (m_row + 1 >= clamp_size(m_height)) begin
        m_row = 0;
        m_phase = 0;
        r.frame_end = 1'b1;
      end else begin
        m_row++;
      end
    end else begin
      m_col++;
    end
    r.hit_mask = m_hits;
    expected_points.push_back(r);
  endtask

  // result checker
  task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    dtp_pkg::out_item_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_points.size() == 0) begin
        errors++;
        $display("%0t unexpected item expected none actual %h", $time, out_item_o);
      end else begin
        e = expected_points.pop_front();
        report_field("point_x", e.point_x, out_item_o.point_x);
        report_field("point_y", e.point_y, out_item_o.point_y);
        report_field("point_z", e.point_z, out_item_o.point_z);
        report_field("hit_mask", 32'(e.hit_mask), 32'(out_item_o.hit_mask));
        report_field("frame_end", 32'(e.frame_end), 32'(out_item_o.frame_end));
      end
    end
  end

  // send one item, then maybe idle
  task automatic send_item(dtp_pkg::in_item_t it);
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(it);
    if (!no_idle && $urandom_range(99) < 32) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic send_pixel(logic [15:0] d);
    dtp_pkg::in_item_t it;
    it = '0;
    it.box_index = 3'($urandom);
    it.box_min_x = $urandom;
    it.box_max_x = $urandom;
    it.box_min_y = $urandom;
    it.box_max_y = $urandom;
    it.box_min_z = $urandom;
    it.box_max_z = $urandom;
    it.cmd = dtp_pkg::CmdPixel;
    it.depth = d;
    send_item(it);
  endtask

  task automatic send_box(logic [2:0] idx, logic signed [31:0] x0, logic signed [31:0] x1,
                          logic signed [31:0] y0, logic signed [31:0] y1,
                          logic signed [31:0] z0, logic signed [31:0] z1);
    dtp_pkg::in_item_t it;
    it.cmd = dtp_pkg::CmdBox;
    it.depth = 16'($urandom);
    it.box_index = idx;
    it.box_min_x = x0;
    it.box_max_x = x1;
    it.box_min_y = y0;
    it.box_max_y = y1;
    it.box_min_z = z0;
    it.box_max_z = z1;
    send_item(it);
  endtask

  // box around the point the next pixel with depth d would give
  task automatic send_box_around(logic [2:0] idx, logic [15:0] d);
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    int signed mx;
    int signed my;
    int signed mz;
    x = lateral_coord(m_col, 320, d);
    y = lateral_coord(m_row, 240, d);
    z = depth_coord(d);
    mx = $urandom_range(1, 1 << $urandom_range(0, 24));
    my = $urandom_range(1, 1 << $urandom_range(0, 24));
    mz = $urandom_range(1, 1 << $urandom_range(0, 24));
    send_box(idx, x - mx, x + mx, y - my, y + my, z - mz, z + mz);
  endtask

  // wait until every result is back and the block has settled
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [dtp_pkg::CfgIdxW-1:0] idx,
                           logic [dtp_pkg::CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      dtp_pkg::RegFocal: m_focal = val;
      dtp_pkg::RegPixel: m_pixel = val;
      dtp_pkg::RegWidth: m_width = val[10:0];
      dtp_pkg::RegHeight: m_height = val[10:0];
      dtp_pkg::RegBoxes: m_boxes = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_frame(int unsigned fw, int unsigned fh, int unsigned nb);
    write_reg(dtp_pkg::RegWidth, 16'(fw));
    write_reg(dtp_pkg::RegHeight, 16'(fh));
    write_reg(dtp_pkg::RegBoxes, 16'(nb));
  endtask

  // every box gets bounds before any hit test is enabled
  task automatic test_box_loads();
    send_box(0, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
             32'sh8000_0000, 32'sh7fff_ffff);
    send_box(1, 0, 0, 0, 0, 0, 0);
    for (int b = 2; b < dtp_pkg::MaxBoxes; b++) send_box_around(3'(b), 16'($urandom));
    drain();
  endtask

  // field extremes on a tiny frame, all boxes tested
  task automatic test_directed_pixels();
    set_frame(4, 2, dtp_pkg::MaxBoxes);
    send_pixel(16'd0);
    send_pixel(16'hffff);
    send_box_around(3, 16'd1234);
    send_pixel(16'd1234);
    for (int i = 0; i < 10; i++) send_pixel(16'($urandom));
    drain();
  endtask

  // register extremes: zero focal, full pitch, clamped sizes, too many boxes
  task automatic test_register_extremes();
    write_reg(dtp_pkg::RegFocal, 16'd0);
    write_reg(dtp_pkg::RegPixel, 16'hffff);
    set_frame(0, 0, 15);
    send_pixel(16'hffff);
    send_pixel(16'd7);
    drain();
    write_reg(dtp_pkg::RegFocal, 16'd1);
    write_reg(dtp_pkg::RegPixel, 16'd0);
    for (int i = 5; i < 8; i++) write_reg(3'(i), 16'h0001);
    send_pixel(16'hffff);
    drain();
    write_reg(dtp_pkg::RegFocal, 16'hffff);
    write_reg(dtp_pkg::RegPixel, 16'hffff);
    set_frame(2047, 1, 1);
    send_pixel(16'hffff);
    drain();
  endtask

  // long rows past the column center, tall columns past the row center
  task automatic test_frame_sweeps();
    write_reg(dtp_pkg::RegFocal, 16'd1);
    write_reg(dtp_pkg::RegPixel, 16'hffff);
    set_frame(1024, 1, 2);
    for (int i = 0; i < 1024; i++) begin
      no_idle = (i < 400);
      send_pixel(16'($urandom));
    end
    no_idle = 1'b0;
    drain();
    write_reg(dtp_pkg::RegFocal, 16'd120);
    write_reg(dtp_pkg::RegPixel, 16'd13658);
    set_frame(1, 300, 2);
    for (int i = 0; i < 260; i++) send_pixel(16'($urandom));
    drain();
    // shrink the frame while the row counter sits beyond the new limit
    set_frame(3, 2, 8);
    send_pixel(16'd500);
    send_pixel(16'd500);
    send_pixel(16'd500);
    drain();
  endtask

  // random phases: random registers, mostly pixels with boxes placed to hit
  task automatic test_random_traffic();
    int unsigned k;
    logic [15:0] d;
    for (int p = 0; p < 8; p++) begin
      write_reg(dtp_pkg::RegFocal, ($urandom_range(3) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(1, 300)));
      write_reg(dtp_pkg::RegPixel, 16'($urandom));
      set_frame($urandom_range(1, 40), $urandom_range(1, 6), $urandom_range(0, 9));
      for (int i = 0; i < 25; i++) begin
        no_idle = (p == 4);
        k = $urandom_range(99);
        d = 16'($urandom);
        if (k < 12) begin
          send_box_around(3'($urandom_range(0, dtp_pkg::MaxBoxes-1)), d);
          send_pixel(d);
        end else if (k < 15) begin
          send_box(3'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom);
        end else begin
          send_pixel(d);
        end
      end
      no_idle = 1'b0;
      drain();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_ready_i = 1'b0;
    errors = 0;
    cycles = 0;
    no_idle = 1'b0;
    m_focal = 16'd120;
    m_pixel = 16'd13658;
    m_width = 11'd640;
    m_height = 11'd480;
    m_boxes = 4'd0;
    m_col = 0;
    m_row = 0;
    m_phase = 0;
    m_hits = '0;
    for (int i = 0; i < dtp_pkg::MaxBoxes*6; i++) m_bounds[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_box_loads();
    test_directed_pixels();
    test_register_extremes();
    test_frame_sweeps();
    test_random_traffic();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
